/* rtl/core/lidar_packet_to_xyz_macros.svh */
// Assertion macros used by the lidar point decoder checker.
`ifndef LIDAR_PACKET_TO_XYZ_MACROS_SVH
`define LIDAR_PACKET_TO_XYZ_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LP2X_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next one.
`define LP2X_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/lp2x_pkg.sv */
// Types, tables and trig helpers of the lidar point decoder.
package lp2x_pkg;

   localparam int FOOTER_BYTES = 6;
   localparam int FULL_TURN    = 36000;
   localparam int QUARTER_TURN = 9000;
   localparam int BEAM_CNT_W   = 6;
   localparam int BLK_CNT_W    = 5;

   // Parser position within a block
   typedef enum logic [2:0] {
      PH_TAG_LO,
      PH_TAG_HI,
      PH_AZ_LO,
      PH_AZ_HI,
      PH_RNG_LO,
      PH_RNG_HI,
      PH_ECHO
   } phase_type;

   // One parsed record, handed from the parser to the math pipeline
   typedef struct packed {
      logic [15:0] range_raw;
      logic [7:0]  echo_strength;
      logic [4:0]  beam_number;
      logic [3:0]  block_number;
      logic [15:0] block_tag;
      logic [15:0] heading;
      logic        last_point;
   } rec_type;

   typedef struct packed {
      logic    valid;
      rec_type rec;
   } rec_xfer_type;

   // round(32768*sin(deg)) for whole degrees, 90 degrees held at 32767
   localparam logic [15:0] QUARTER_SINE [0:90] = '{
      16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
      16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927,
      16'd8481, 16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743,
      16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384,
      16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795,
      16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926,
      16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
      16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166,
      16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197,
      16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792,
      16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928,
      16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
      16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32767
   };

   // Beam elevations in hundredths of a degree
   localparam int ELEV_CDEG [0:31] = '{
      -3067, -933, -2933, -800, -2800, -666, -2666, -533,
      -2533, -400, -2400, -267, -2267, -133, -2133, 0,
      -2000, 133, -1867, 267, -1733, 400, -1600, 533,
      -1467, 667, -1333, 800, -1200, 933, -1067, 1067
   };

   // Sine or cosine of a beam elevation: {negative, Q1.15 magnitude}.
   // Depends on the beam index only, so it folds into a small table.
   function automatic logic [16:0] elev_trig(input logic [4:0] idx, input logic want_cos);
      int ecd;
      int code;
      int q;
      int r;
      int d;
      int f;
      int mag;
      ecd  = ELEV_CDEG[idx];
      code = (ecd < 0) ? FULL_TURN + ecd : ecd;
      if (want_cos) code = code + QUARTER_TURN;
      code = code % FULL_TURN;
      q    = code / QUARTER_TURN;
      r    = code % QUARTER_TURN;
      if (q % 2 == 1) r = QUARTER_TURN - r;
      d = r / 100;
      f = r % 100;
      if (d >= 90) mag = int'(QUARTER_SINE[90]);
      else mag = int'(QUARTER_SINE[d]) +
                 ((int'(QUARTER_SINE[d + 1]) - int'(QUARTER_SINE[d])) * f + 50) / 100;
      return {(q >= 2), 16'(mag)};
   endfunction

endpackage

/* rtl/core/lp2x_front.sv */
// Byte parser: walks the frame and emits one record per intensity byte.
module lp2x_front #(
   parameter int BEAMS_PER_BLOCK  = 32,
   parameter int BLOCKS_PER_FRAME = 12,
   parameter int HEADER_BYTES     = 42
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             data_byte,
   input  logic                   frame_start,
   input  logic [15:0]            frame_length,
   input  logic                   room,
   output lp2x_pkg::rec_xfer_type push
);
   import lp2x_pkg::*;

   localparam int HW = $clog2(HEADER_BYTES + 2);
   localparam logic [15:0] FRAME_LEN =
      16'(HEADER_BYTES + BLOCKS_PER_FRAME * (4 + 3 * BEAMS_PER_BLOCK) + FOOTER_BYTES);

   phase_type             ph_ff, ph_in, ph_c;
   logic [HW-1:0]         pos_ff, pos_in, pos_c;
   logic                  good_ff, good_in, good_c;
   logic [BLK_CNT_W-1:0]  blk_ff, blk_in, blk_c;
   logic [BEAM_CNT_W-1:0] beam_ff, beam_in, beam_c;
   logic [15:0]           tag_ff, tag_in;
   logic [15:0]           az_ff, az_in;
   logic [15:0]           rng_ff, rng_in;
   logic                  accept;
   logic                  beam_end;

   assign in_ready = room;
   assign accept   = in_valid & room;

   // Phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_TAG_LO;
      end else begin
         ph_ff <= ph_in;
      end
   end

   // Counters and held fields
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         good_ff <= 1'b0;
         blk_ff  <= '0;
         beam_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         good_ff <= good_in;
         blk_ff  <= blk_in;
         beam_ff <= beam_in;
      end
      tag_ff <= tag_in;
      az_ff  <= az_in;
      rng_ff <= rng_in;
   end

   // Parse step for the accepted byte
   always_comb begin
      pos_c  = pos_ff;
      good_c = good_ff;
      blk_c  = blk_ff;
      beam_c = beam_ff;
      ph_c   = ph_ff;
      if (frame_start) begin
         pos_c  = '0;
         good_c = (frame_length == FRAME_LEN);
         blk_c  = '0;
         beam_c = '0;
         ph_c   = PH_TAG_LO;
      end
      pos_in  = pos_ff;
      good_in = good_ff;
      blk_in  = blk_ff;
      beam_in = beam_ff;
      ph_in   = ph_ff;
      tag_in  = tag_ff;
      az_in   = az_ff;
      rng_in  = rng_ff;
      beam_end = (beam_c == BEAM_CNT_W'(BEAMS_PER_BLOCK - 1));
      push.valid = 1'b0;
      push.rec.range_raw     = rng_ff;
      push.rec.echo_strength = data_byte;
      push.rec.beam_number   = beam_c[4:0];
      push.rec.block_number  = blk_c[3:0];
      push.rec.block_tag     = tag_ff;
      push.rec.heading       = (az_ff >= 16'(FULL_TURN)) ? az_ff - 16'(FULL_TURN) : az_ff;
      push.rec.last_point    = beam_end & (blk_c == BLK_CNT_W'(BLOCKS_PER_FRAME - 1));
      if (accept) begin
         pos_in  = pos_c;
         good_in = good_c;
         blk_in  = blk_c;
         beam_in = beam_c;
         ph_in   = ph_c;
         if (good_c && pos_c < HW'(HEADER_BYTES)) begin
            pos_in = pos_c + 1'b1;
         end else if (good_c && blk_c < BLK_CNT_W'(BLOCKS_PER_FRAME)) begin
            unique case (ph_c)
               PH_TAG_LO: begin
                  tag_in = {tag_ff[15:8], data_byte};
                  ph_in  = PH_TAG_HI;
               end
               PH_TAG_HI: begin
                  tag_in = {data_byte, tag_ff[7:0]};
                  ph_in  = PH_AZ_LO;
               end
               PH_AZ_LO: begin
                  az_in = {az_ff[15:8], data_byte};
                  ph_in = PH_AZ_HI;
               end
               PH_AZ_HI: begin
                  az_in = {data_byte, az_ff[7:0]};
                  ph_in = PH_RNG_LO;
               end
               PH_RNG_LO: begin
                  rng_in = {rng_ff[15:8], data_byte};
                  ph_in  = PH_RNG_HI;
               end
               PH_RNG_HI: begin
                  rng_in = {data_byte, rng_ff[7:0]};
                  ph_in  = PH_ECHO;
               end
               PH_ECHO: begin
                  push.valid = 1'b1;
                  if (beam_end) begin
                     beam_in = '0;
                     ph_in   = PH_TAG_LO;
                     blk_in  = blk_c + 1'b1;
                  end else begin
                     beam_in = beam_c + 1'b1;
                     ph_in   = PH_RNG_LO;
                  end
               end
               default: ph_in = PH_TAG_LO;
            endcase
         end
      end
   end

endmodule

/* rtl/core/lp2x_queue.sv */
// Four-entry record queue between parser and math pipeline.
module lp2x_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  lp2x_pkg::rec_xfer_type push,
   input  logic                   pop,
   output logic                   room,
   output lp2x_pkg::rec_xfer_type head
);
   import lp2x_pkg::*;

   rec_type    mem_ff [4];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_pop;

   assign room       = (cnt_ff != 3'd4);
   assign do_pop     = pop & (cnt_ff != 3'd0);
   assign head.valid = (cnt_ff != 3'd0);
   assign head.rec   = mem_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in  = push.valid ? wr_ff + 2'd1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, push.valid} - {2'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ff] <= push.rec;
      end
   end

endmodule

/* rtl/core/lp2x_back.sv */
// Math pipeline: trig lookup, scaling and rounding of one record per cycle while the output is not stalled.
module lp2x_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lp2x_pkg::rec_xfer_type head,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [16:0]            point_x,
   output logic [16:0]            point_y,
   output logic [16:0]            point_z,
   output lp2x_pkg::rec_type      out_rec
);
   import lp2x_pkg::*;

   // {negative, residue within a quarter turn}
   function automatic logic [14:0] reduce_angle(input logic [15:0] a);
      logic [1:0]  q;
      logic [15:0] rem;
      if (a >= 16'd27000) q = 2'd3;
      else if (a >= 16'd18000) q = 2'd2;
      else if (a >= 16'd9000) q = 2'd1;
      else q = 2'd0;
      rem = a - 16'(q * QUARTER_TURN);
      if (q[0]) rem = 16'(QUARTER_TURN) - rem;
      return {q[1], rem[13:0]};
   endfunction

   // n/100 for n below 2^16 by reciprocal multiply
   function automatic logic [9:0] div100(input logic [15:0] n);
      logic [33:0] p;
      p = {18'd0, n} * 34'd167773;
      return p[33:24];
   endfunction

   logic        en;
   logic [15:0] az_c;
   logic [14:0] red_s, red_c;
   logic [9:0]  q_s, q_c;
   logic [6:0]  d1_s, d1_c;
   logic [15:0] t1_s, t1_c;
   logic [9:0]  n4_s, n4_c;

   // elevation sine and cosine per beam, constant tables
   logic [16:0] se_tab [32];
   logic [16:0] ce_tab [32];

   // stage 1: angle reduction, elevation lookup
   logic        v1_ff;
   rec_type     r1_ff;
   logic [13:0] rs1_ff, rc1_ff;
   logic        ns1_ff, nc1_ff;
   logic [16:0] se1_ff, ce1_ff;
   // stage 2: degree and hundredths split
   logic        v2_ff;
   rec_type     r2_ff;
   logic [6:0]  ds2_ff, dc2_ff, fs2_ff, fc2_ff;
   logic        ns2_ff, nc2_ff;
   logic [16:0] se2_ff, ce2_ff;
   // stage 3: table read and slope product
   logic        v3_ff;
   rec_type     r3_ff;
   logic [15:0] ts3_ff, tc3_ff, ns3v_ff, nc3v_ff;
   logic        ns3_ff, nc3_ff;
   logic [16:0] se3_ff, ce3_ff;
   // stage 4: interpolated magnitudes
   logic        v4_ff;
   rec_type     r4_ff;
   logic [15:0] sa4_ff, ca4_ff;
   logic        ns4_ff, nc4_ff;
   logic [16:0] se4_ff, ce4_ff;
   // stage 5: range times elevation terms
   logic        v5_ff;
   rec_type     r5_ff;
   logic [15:0] sa5_ff, ca5_ff;
   logic        negx5_ff, negy5_ff, negz5_ff;
   logic [31:0] pc5_ff, pz5_ff;
   // stage 6: times azimuth terms
   logic        v6_ff;
   rec_type     r6_ff;
   logic        negx6_ff, negy6_ff, negz6_ff;
   logic [47:0] px6_ff, py6_ff;
   logic [31:0] pz6_ff;
   // stage 7: rounded result register
   logic        v7_ff;
   rec_type     r7_ff;
   logic [16:0] x7_ff, y7_ff, z7_ff;

   logic [18:0] vx, vy;
   logic [17:0] vz;

   assign en        = ~v7_ff | out_ready;
   assign pop       = en & head.valid;
   assign out_valid = v7_ff;
   assign point_x   = x7_ff;
   assign point_y   = y7_ff;
   assign point_z   = z7_ff;
   assign out_rec   = r7_ff;

   // Elevation tables, evaluated from constants only
   for (genvar i = 0; i < 32; i++) begin : g_elev
      assign se_tab[i] = elev_trig(5'(i), 1'b0);
      assign ce_tab[i] = elev_trig(5'(i), 1'b1);
   end

   // Datapath helpers
   always_comb begin
      az_c  = head.rec.heading + 16'(QUARTER_TURN);
      if (az_c >= 16'(FULL_TURN)) az_c = az_c - 16'(FULL_TURN);
      red_s = reduce_angle(head.rec.heading);
      red_c = reduce_angle(az_c);
      q_s   = div100({2'b0, rs1_ff});
      q_c   = div100({2'b0, rc1_ff});
      d1_s  = (ds2_ff >= 7'd90) ? 7'd90 : ds2_ff + 7'd1;
      d1_c  = (dc2_ff >= 7'd90) ? 7'd90 : dc2_ff + 7'd1;
      t1_s  = QUARTER_SINE[d1_s];
      t1_c  = QUARTER_SINE[d1_c];
      n4_s  = div100(ns3v_ff);
      n4_c  = div100(nc3v_ff);
      vx    = 19'((49'(px6_ff) + 49'h2000_0000) >> 30);
      vy    = 19'((49'(py6_ff) + 49'h2000_0000) >> 30);
      vz    = 18'((33'(pz6_ff) + 33'h4000) >> 15);
   end

   // Control: valid bits advance together
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= head.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff  <= head.rec;
         rs1_ff <= red_s[13:0];
         ns1_ff <= red_s[14];
         rc1_ff <= red_c[13:0];
         nc1_ff <= red_c[14];
         se1_ff <= se_tab[head.rec.beam_number];
         ce1_ff <= ce_tab[head.rec.beam_number];

         r2_ff  <= r1_ff;
         ds2_ff <= q_s[6:0];
         dc2_ff <= q_c[6:0];
         fs2_ff <= 7'(rs1_ff - 14'({7'd0, q_s[6:0]} * 14'd100));
         fc2_ff <= 7'(rc1_ff - 14'({7'd0, q_c[6:0]} * 14'd100));
         ns2_ff <= ns1_ff;
         nc2_ff <= nc1_ff;
         se2_ff <= se1_ff;
         ce2_ff <= ce1_ff;

         r3_ff   <= r2_ff;
         ts3_ff  <= QUARTER_SINE[ds2_ff];
         tc3_ff  <= QUARTER_SINE[dc2_ff];
         ns3v_ff <= 16'((t1_s - QUARTER_SINE[ds2_ff]) * {9'd0, fs2_ff}) + 16'd50;
         nc3v_ff <= 16'((t1_c - QUARTER_SINE[dc2_ff]) * {9'd0, fc2_ff}) + 16'd50;
         ns3_ff  <= ns2_ff;
         nc3_ff  <= nc2_ff;
         se3_ff  <= se2_ff;
         ce3_ff  <= ce2_ff;

         r4_ff  <= r3_ff;
         sa4_ff <= ts3_ff + {6'd0, n4_s};
         ca4_ff <= tc3_ff + {6'd0, n4_c};
         ns4_ff <= ns3_ff;
         nc4_ff <= nc3_ff;
         se4_ff <= se3_ff;
         ce4_ff <= ce3_ff;

         r5_ff    <= r4_ff;
         sa5_ff   <= sa4_ff;
         ca5_ff   <= ca4_ff;
         negx5_ff <= ce4_ff[16] ^ ns4_ff;
         negy5_ff <= ce4_ff[16] ^ nc4_ff;
         negz5_ff <= se4_ff[16];
         pc5_ff   <= {16'd0, r4_ff.range_raw} * {16'd0, ce4_ff[15:0]};
         pz5_ff   <= {16'd0, r4_ff.range_raw} * {16'd0, se4_ff[15:0]};

         r6_ff    <= r5_ff;
         negx6_ff <= negx5_ff;
         negy6_ff <= negy5_ff;
         negz6_ff <= negz5_ff;
         px6_ff   <= {16'd0, pc5_ff} * {32'd0, sa5_ff};
         py6_ff   <= {16'd0, pc5_ff} * {32'd0, ca5_ff};
         pz6_ff   <= pz5_ff;

         r7_ff <= r6_ff;
         x7_ff <= negx6_ff ? 17'(-vx) : vx[16:0];
         y7_ff <= negy6_ff ? 17'(-vy) : vy[16:0];
         z7_ff <= negz6_ff ? 17'(-vz) : vz[16:0];
      end
   end

endmodule

/* rtl/core/lidar_packet_to_xyz.sv */
// Top level: lidar frame bytes in, Cartesian points out.
// Takes one frame byte per cycle when the record queue has room.
// After its intensity byte is accepted, a point passes through the record queue and the math pipeline.
// The math pipeline takes one record per cycle unless stalled; a frame yields at most one point per 3 bytes.
// Synchronous active-high reset clears the parser, queue and pipeline valid bits.
module lidar_packet_to_xyz #(
   parameter int BEAMS_PER_BLOCK  = 32,
   parameter int BLOCKS_PER_FRAME = 12,
   parameter int HEADER_BYTES     = 42
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,  // data_byte[7:0], frame_length[23:8]
   input  logic         req_tuser,  // frame_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // point_x, point_y, point_z, range_raw, echo_strength, beam_number,
   // block_number, block_tag, heading, zero pad
   output logic [119:0] rsp_tdata,
   output logic         rsp_tlast   // last_point
);
   import lp2x_pkg::*;

   rec_xfer_type push;
   rec_xfer_type head;
   rec_type      out_rec;
   logic         room;
   logic         pop;
   logic [16:0]  point_x, point_y, point_z;

   lp2x_front #(
      .BEAMS_PER_BLOCK (BEAMS_PER_BLOCK),
      .BLOCKS_PER_FRAME(BLOCKS_PER_FRAME),
      .HEADER_BYTES    (HEADER_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .data_byte   (req_tdata[7:0]),
      .frame_start (req_tuser),
      .frame_length(req_tdata[23:8]),
      .room        (room),
      .push        (push)
   );

   lp2x_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .pop  (pop),
      .room (room),
      .head (head)
   );

   lp2x_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .point_x  (point_x),
      .point_y  (point_y),
      .point_z  (point_z),
      .out_rec  (out_rec)
   );

   // Pack the result transfer
   assign rsp_tdata = {4'd0, out_rec.heading, out_rec.block_tag, out_rec.block_number,
                       out_rec.beam_number, out_rec.echo_strength, out_rec.range_raw,
                       point_z, point_y, point_x};
   assign rsp_tlast = out_rec.last_point;

endmodule

/* rtl/core/lp2x_checker.sv */
// Port-level checks of the lidar point decoder, bound to the top level.
`include "lidar_packet_to_xyz_macros.svh"

module lp2x_checker #(
   parameter int BEAMS_PER_BLOCK = 32
) (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic         rsp_tlast
);

   // A stalled result transfer keeps its payload
   `LP2X_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // Nothing leaves right after reset
   `LP2X_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")

   // Heading is always below a full turn
   `LP2X_ASSERT(a_heading, clock, reset, !rsp_tvalid || rsp_tdata[115:100] < 16'd36000, "heading out of range")

   // Frame end falls on the last beam of a block
   `LP2X_ASSERT(a_last_beam, clock, reset, !(rsp_tvalid && rsp_tlast) || rsp_tdata[79:75] == 5'(BEAMS_PER_BLOCK - 1), "last point not on last beam")

endmodule

bind lidar_packet_to_xyz lp2x_checker #(
   .BEAMS_PER_BLOCK(BEAMS_PER_BLOCK)
) u_lp2x_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);

/* dv/lidar_packet_to_xyz_checker.sv */
// Point predictor and scoreboard for the lidar frame decoder.
module lidar_packet_to_xyz_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [23:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [119:0] rsp_tdata,
   input  logic         rsp_tlast,
   output int           error_count,
   output int           points_pending,
   output int           points_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import lp2x_pkg::*;

   localparam int BEAMS  = 32;
   localparam int BLOCKS = 12;
   localparam int HEADER = 42;
   localparam int FRAME_LEN = HEADER + BLOCKS * (4 + 3 * BEAMS) + FOOTER_BYTES;

   typedef struct packed {
      logic [16:0] x;
      logic [16:0] y;
      logic [16:0] z;
      logic [15:0] range_raw;
      logic [7:0]  echo;
      logic [4:0]  beam;
      logic [3:0]  block;
      logic [15:0] tag;
      logic [15:0] heading;
      logic        last;
   } point_type;

   point_type point_q[$];

   // decoder state mirror
   int          hdr_count;
   bit          frame_ok;
   int          blk_idx;
   int          beam_idx;
   phase_type   phase;
   logic [15:0] tag_hold;
   logic [15:0] az_hold;
   logic [15:0] range_hold;

   // Q1.15 sine magnitude of an angle in hundredths of a degree, with sign
   function automatic int sine_cdeg(input int angle, output bit neg);
      int a;
      int quad;
      int rem;
      int deg;
      int frac;
      a    = angle % FULL_TURN;
      quad = a / QUARTER_TURN;
      rem  = a % QUARTER_TURN;
      if (quad % 2 == 1) rem = QUARTER_TURN - rem;
      neg  = (quad >= 2);
      deg  = rem / 100;
      frac = rem % 100;
      if (deg >= 90) return int'(QUARTER_SINE[90]);
      return int'(QUARTER_SINE[deg]) +
             ((int'(QUARTER_SINE[deg + 1]) - int'(QUARTER_SINE[deg])) * frac + 50) / 100;
   endfunction

   // round half away from zero after the shift, then apply sign
   function automatic logic [16:0] scale_round(input longint unsigned prod, input int sh,
                                               input bit neg);
      longint unsigned v;
      v = (prod + (64'd1 << (sh - 1))) >> sh;
      if (neg) v = 64'd0 - v;
      return v[16:0];
   endfunction

   function automatic point_type make_point(input logic [7:0] echo);
      point_type p;
      int az;
      int el;
      int sa, ca, se, ce;
      bit sa_n, ca_n, se_n, ce_n;
      az = az_hold;
      if (az >= FULL_TURN) az -= FULL_TURN;
      el = ELEV_CDEG[beam_idx % 32];
      if (el < 0) el += FULL_TURN;
      sa = sine_cdeg(az, sa_n);
      ca = sine_cdeg(az + QUARTER_TURN, ca_n);
      se = sine_cdeg(el, se_n);
      ce = sine_cdeg(el + QUARTER_TURN, ce_n);
      p.x = scale_round(longint'(range_hold) * ce * sa, 30, ce_n != sa_n);
      p.y = scale_round(longint'(range_hold) * ce * ca, 30, ce_n != ca_n);
      p.z = scale_round(longint'(range_hold) * se, 15, se_n);
      p.range_raw = range_hold;
      p.echo      = echo;
      p.beam      = 5'(beam_idx);
      p.block     = 4'(blk_idx);
      p.tag       = tag_hold;
      p.heading   = 16'(az);
      p.last      = (blk_idx == BLOCKS - 1) && (beam_idx == BEAMS - 1);
      return p;
   endfunction

   assign points_pending = point_q.size();

   always @(posedge clock) begin
      point_type got;
      point_type want;
      logic [7:0] b;
      if (reset) begin
         hdr_count <= 0;
         frame_ok  <= 0;
         blk_idx   <= 0;
         beam_idx  <= 0;
         phase     <= PH_TAG_LO;
         tag_hold  <= '0;
         az_hold   <= '0;
         range_hold <= '0;
      end else begin
         // result transfer: compare against the oldest predicted point
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[16:0], rsp_tdata[33:17], rsp_tdata[50:34], rsp_tdata[66:51],
                    rsp_tdata[74:67], rsp_tdata[79:75], rsp_tdata[83:80], rsp_tdata[99:84],
                    rsp_tdata[115:100], rsp_tlast};
            points_checked++;
            if (point_q.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("unexpected point %p", got);
            end else begin
               want = point_q.pop_front();
               if (got != want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("point mismatch\n  exp %p\n  act %p", want, got);
               end
            end
         end
         // byte transfer: advance the parser mirror (blocking, read below)
         if (req_tvalid && req_tready) begin
            b = req_tdata[7:0];
            if (req_tuser) begin
               hdr_count = 0;
               frame_ok  = (req_tdata[23:8] == 16'(FRAME_LEN));
               blk_idx   = 0;
               beam_idx  = 0;
               phase     = PH_TAG_LO;
            end
            if (!frame_ok) begin
            end else if (hdr_count < HEADER) begin
               hdr_count++;
            end else if (blk_idx < BLOCKS) begin
               case (phase)
                  PH_TAG_LO: begin tag_hold[7:0] = b;    phase = PH_TAG_HI; end
                  PH_TAG_HI: begin tag_hold[15:8] = b;   phase = PH_AZ_LO;  end
                  PH_AZ_LO:  begin az_hold[7:0] = b;     phase = PH_AZ_HI;  end
                  PH_AZ_HI:  begin az_hold[15:8] = b;    phase = PH_RNG_LO; end
                  PH_RNG_LO: begin range_hold[7:0] = b;  phase = PH_RNG_HI; end
                  PH_RNG_HI: begin range_hold[15:8] = b; phase = PH_ECHO;   end
                  default: begin
                     point_q.insert(point_q.size(), make_point(b));
                     if (beam_idx + 1 >= BEAMS) begin
                        beam_idx = 0;
                        phase    = PH_TAG_LO;
                        blk_idx++;
                     end else begin
                        beam_idx++;
                        phase = PH_RNG_LO;
                     end
                  end
               endcase
            end
         end
      end
   end

   initial begin
      error_count    = 0;
      points_checked = 0;
   end
endmodule

/* dv/lidar_packet_to_xyz_test.sv */
// Testbench top: frame stimulus, output flow control and verdict.
module lidar_packet_to_xyz_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LEN = 1248;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [23:0]  req_tdata;  // data_byte[7:0], frame_length[23:8]
   logic         req_tuser;  // frame_start
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [119:0] rsp_tdata;  // x, y, z, range, echo, beam, block, tag, heading, pad
   logic         rsp_tlast;  // last_point

   int error_count;
   int points_pending;
   int points_checked;
   int idle_pct;
   int stall_pct;
   int hold_cycles;
   int bytes_sent;
   int cycle_count;
   logic [7:0] frame_q[$];

   lidar_packet_to_xyz dut (.*);

   lidar_packet_to_xyz_checker scoreboard (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off when requested
   initial begin
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // one byte transfer, with an optional idle gap ahead of it
   task automatic send_byte(input logic [7:0] b, input logic start, input logic [15:0] len);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {len, b};
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // send bytes first..last-1 of frame_q, start flagged on byte zero
   task automatic send_bytes(input logic [15:0] len, input int first, input int last);
      for (int i = first; i < last; i++)
         send_byte(i < frame_q.size() ? frame_q[i] : 8'($urandom), i == 0, len);
   endtask

   // add one byte at the end of frame_q
   task automatic add_byte(input logic [7:0] b);
      frame_q.insert(frame_q.size(), b);
   endtask

   // fill frame_q; directed frames hit the extremes of range, angle and tag
   task automatic build_frame(input bit directed);
      logic [15:0] az;
      logic [15:0] rng;
      logic [15:0] tag;
      logic [7:0]  echo;
      int az_list[12] = '{0, 35999, 36000, 65535, 9000, 18000, 27000, 4500,
                          12345, 100, 8999, 30000};
      frame_q.delete();
      for (int i = 0; i < 42; i++) add_byte(8'($urandom));
      for (int blk = 0; blk < 12; blk++) begin
         tag = directed ? (blk == 0 ? 16'h0000 : blk == 1 ? 16'hFFFF : 16'($urandom))
                        : 16'($urandom);
         if (directed) az = 16'(az_list[blk]);
         else if ($urandom_range(9) == 0) az = 16'($urandom_range(65535, 36000));
         else az = 16'($urandom_range(35999));
         add_byte(tag[7:0]);
         add_byte(tag[15:8]);
         add_byte(az[7:0]);
         add_byte(az[15:8]);
         for (int bm = 0; bm < 32; bm++) begin
            case ($urandom_range(7))
               0: rng = 16'h0000;
               1: rng = 16'hFFFF;
               default: rng = 16'($urandom);
            endcase
            echo = 8'($urandom);
            if (directed && bm < 2) begin
               rng  = bm == 0 ? 16'h0000 : 16'hFFFF;
               echo = bm == 0 ? 8'h00 : 8'hFF;
            end
            add_byte(rng[7:0]);
            add_byte(rng[15:8]);
            add_byte(echo);
         end
      end
      for (int i = 0; i < 6; i++) add_byte(8'($urandom));
   endtask

   // frame with a length the block must reject
   task automatic send_bad_frame(input logic [15:0] len, input int count);
      if (len == FRAME_LEN) len = len + 16'd1;
      build_frame(0);
      send_bytes(len, 0, count);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = '0;
      req_tuser   = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      hold_cycles = 0;
      bytes_sent  = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // stray bytes before any frame start are ignored
      for (int i = 0; i < 3; i++) send_byte(8'($urandom), 0, FRAME_LEN);

      // no idling: rejected lengths, one running past the header
      send_bad_frame(16'h0000, 4);
      send_bad_frame(16'hFFFF, 4);
      send_bad_frame(16'(FRAME_LEN - 1), 48);
      send_bad_frame(16'($urandom), 4);

      // a good frame cut short after a few records
      build_frame(0);
      send_bytes(FRAME_LEN, 0, 52);

      // directed full frame with surplus bytes, flow control changing inside it
      build_frame(1);
      send_bytes(FRAME_LEN, 0, 312);

      // sender idles
      idle_pct = 56;
      send_bytes(FRAME_LEN, 312, 624);

      // sender pauses until every point is out
      drain();

      // receiver stalls, with a long hold-off so the input backs up
      idle_pct    = 0;
      stall_pct   = 56;
      hold_cycles = 300;
      send_bytes(FRAME_LEN, 624, 936);

      // both sides idle, through the footer and some surplus
      idle_pct  = 35;
      stall_pct = 35;
      send_bytes(FRAME_LEN, 936, FRAME_LEN + 4);

      drain();
      stall_pct = 0;
      repeat (30) @(posedge clock);
      $display("sent %0d frame bytes over good, short, rejected and padded frames",
               bytes_sent);
      $display("checked %0d points under idle, stall and hold-off phases", points_checked);
      if (error_count == 0 && points_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d points never arrived", error_count, points_pending);
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
